// ----- hw/rtl/cau_pkg.sv -----
// Shared types, constants and helper functions of the complex arithmetic unit.
// Used by every module of the unit; depends on nothing else.
`default_nettype none

package cau_pkg;

    typedef enum logic [3:0] {
        K_ADD   = 4'd0,
        K_SUB   = 4'd1,
        K_MUL   = 4'd2,
        K_DIV   = 4'd3,
        K_CONJ  = 4'd4,
        K_RECIP = 4'd5,
        K_NEG   = 4'd6,
        K_MAG   = 4'd7,
        K_ANGLE = 4'd8
    } t_kind;

    // Quotient bits produced by the division steps, root bits by the square root steps.
    localparam int DIV_STEPS    = 34;
    localparam int SQRT_STEPS   = 32;
    localparam int N_CELLS      = 34;
    localparam int NORM_STEPS   = 6;
    localparam int FRONT_STAGES = 10;

    localparam logic [33:0] HALF_PI_Q30     = 34'd1686629713;
    localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
    localparam logic [31:0] POS_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX         = 32'h8000_0000;

    typedef struct packed {
        logic [3:0]          kind;
        logic signed [31:0]  a_real;
        logic signed [31:0]  a_imag;
        logic signed [31:0]  b_real;
        logic signed [31:0]  b_imag;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0]  res_real;
        logic signed [31:0]  res_imag;
        logic                zero_divisor;
        logic                saturated;
    } t_out_beat;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } t_sat32;

    typedef struct packed {
        logic        neg;
        logic [63:0] mag;
    } t_sm;

    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [63:0] rem;
        logic [33:0] low;
        logic [33:0] q;
    } t_div_lane;

    // Everything one item carries down the pipeline.
    typedef struct packed {
        logic [3:0]          kind;
        logic                zd;
        logic                sat;
        logic [31:0]         re;
        logic [31:0]         im;
        logic signed [63:0]  p_rr;
        logic signed [63:0]  p_ii;
        logic signed [63:0]  p_ir;
        logic signed [63:0]  p_ri;
        logic [63:0]         sq_r;
        logic [63:0]         sq_i;
        t_sm                 d;
        t_sm                 c;
        t_sm                 mr;
        t_sm                 mi;
        logic [63:0]         den;
        t_div_lane [1:0]     dv;
        logic [63:0]         rad;
        logic [34:0]         srem;
        logic [31:0]         root;
        logic [63:0]         ndm;
        logic [63:0]         ncm;
        logic [63:0]         nmx;
        logic signed [33:0]  x;
        logic signed [33:0]  y;
        logic signed [33:0]  z;
        logic [31:0]         zc;
        logic [61:0]         angp;
    } t_work;

    function automatic t_sat32 clamp33(input logic signed [32:0] v);
        t_sat32 r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > 33'sh0_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.val = POS_MAX;
        end else if (v < 33'sh1_8000_0000) begin
            r.sat = 1'b1;
            r.val = NEG_MAX;
        end
        return r;
    endfunction

    // Sign and magnitude into a clamped 32-bit two's complement word.
    function automatic t_sat32 fin_sm(input logic neg, input logic [64:0] mag);
        t_sat32 r;
        r.sat = 1'b0;
        if (!neg) begin
            if (mag > 65'(POS_MAX)) begin
                r.sat = 1'b1;
                r.val = POS_MAX;
            end else begin
                r.val = mag[31:0];
            end
        end else begin
            if (mag > 65'(NEG_MAX)) begin
                r.sat = 1'b1;
                r.val = NEG_MAX;
            end else begin
                r.val = ~mag[31:0] + 32'd1;
            end
        end
        return r;
    endfunction

    function automatic t_sm to_sm(input logic signed [65:0] v);
        t_sm r;
        r.neg = v[65];
        r.mag = v[65] ? 64'(-v) : v[63:0];
        return r;
    endfunction

    // atan(2^-i) in Q2.30 radians.
    function automatic logic [33:0] atan_q30(input logic [4:0] i);
        logic [33:0] r;
        case (i)
            5'd0:  r = 34'd843314857;
            5'd1:  r = 34'd497837829;
            5'd2:  r = 34'd263043837;
            5'd3:  r = 34'd133525159;
            5'd4:  r = 34'd67021687;
            5'd5:  r = 34'd33543516;
            5'd6:  r = 34'd16775851;
            5'd7:  r = 34'd8388437;
            5'd8:  r = 34'd4194283;
            5'd9:  r = 34'd2097149;
            5'd10: r = 34'd1048576;
            5'd11: r = 34'd524288;
            5'd12: r = 34'd262144;
            5'd13: r = 34'd131072;
            5'd14: r = 34'd65536;
            5'd15: r = 34'd32768;
            5'd16: r = 34'd16384;
            5'd17: r = 34'd8192;
            5'd18: r = 34'd4096;
            5'd19: r = 34'd2048;
            5'd20: r = 34'd1024;
            5'd21: r = 34'd512;
            5'd22: r = 34'd256;
            5'd23: r = 34'd128;
            5'd24: r = 34'd64;
            5'd25: r = 34'd32;
            5'd26: r = 34'd16;
            5'd27: r = 34'd8;
            5'd28: r = 34'd4;
            5'd29: r = 34'd2;
            5'd30: r = 34'd1;
            default: r = 34'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/complex_arithmetic_unit.sv -----
// Complex arithmetic unit, top level; uses cau_pkg, cau_front, cau_cell, cau_back.
// Every operation passes through 10 front stages, 34 cells and 2 back stages.
// Throughput is one beat per cycle when not held; the 34 division cells set the depth.
// The whole pipeline advances together and holds only while a result waits at the output.
// Synchronous active-low reset clears all valid bits and sets the angle unit to radians.
`default_nettype none

module complex_arithmetic_unit #(
    parameter int FRAC_BITS        = 16,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Operand channel.
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  cau_pkg::t_in_beat   i_in_data,
    // Result channel.
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output cau_pkg::t_out_beat  o_out_data,
    // Register port.
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // The only register, angle_in_degrees, sits at byte address 0.
    logic r_angle_in_degrees;
    logic en;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_in_degrees <= 1'b0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_angle_in_degrees <= pwdata[0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {31'd0, r_angle_in_degrees};

    // Every stage moves when the output register is empty or its beat is taken.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic           c_valid [cau_pkg::N_CELLS + 1];
    cau_pkg::t_work c_work  [cau_pkg::N_CELLS + 1];

    // Products, sums and setup of the per-cell work.
    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_beat  (i_in_data),
        .o_valid (c_valid[0]),
        .o_work  (c_work[0])
    );

    // The chain: each cell retires one quotient bit on both division lanes, the first
    // 32 a root bit and the first ANGLE_ITERATIONS a rotation; then the item moves on.
    for (genvar k = 0; k < cau_pkg::N_CELLS; k++) begin : g_cell
        cau_cell #(
            .IDX              (k),
            .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_valid[k]),
            .i_work  (c_work[k]),
            .o_valid (c_valid[k + 1]),
            .o_work  (c_work[k + 1])
        );
    end

    // Rounding, clamping and the output register.
    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_deg   (r_angle_in_degrees),
        .i_valid (c_valid[cau_pkg::N_CELLS]),
        .i_work  (c_work[cau_pkg::N_CELLS]),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/cau_front.sv -----
// Front pipeline: operand products, sums, rounding of products, setup of the
// division and root steps, normalization of the angle vector. Uses cau_pkg.
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_en,
    input  wire                   i_valid,
    input  cau_pkg::t_in_beat     i_beat,
    output logic                  o_valid,
    output cau_pkg::t_work        o_work
);

    localparam int RSH = cau_pkg::DIV_STEPS - FRAC_BITS;
    localparam int NS  = cau_pkg::FRONT_STAGES;

    logic           r_v [NS];
    cau_pkg::t_work r_w [NS];
    cau_pkg::t_work n_w [NS];

    logic signed [31:0] xr, xi, yr, yi;
    cau_pkg::t_sat32    s_re, s_im;
    logic [64:0]        rnd_r, rnd_i;
    logic [63:0]        m_lane [2];
    logic signed [33:0] dmn, cmn, x0;
    int                 sh;

    always_comb begin
        // Stage 0: operand selection, products and the simple operations.
        n_w[0]      = '0;
        n_w[0].kind = i_beat.kind;
        xr = i_beat.a_real;
        xi = i_beat.a_imag;
        yr = i_beat.b_real;
        yi = i_beat.b_imag;
        if (i_beat.kind == cau_pkg::K_RECIP) begin
            xr = 32'sd1 <<< FRAC_BITS;
            xi = '0;
        end
        if (i_beat.kind == cau_pkg::K_RECIP || i_beat.kind == cau_pkg::K_MAG) begin
            yr = i_beat.a_real;
            yi = i_beat.a_imag;
        end
        n_w[0].p_rr = xr * yr;
        n_w[0].p_ii = xi * yi;
        n_w[0].p_ir = xi * yr;
        n_w[0].p_ri = xr * yi;
        n_w[0].sq_r = 64'(yr * yr);
        n_w[0].sq_i = 64'(yi * yi);
        s_re = '0;
        s_im = '0;
        case (i_beat.kind)
            cau_pkg::K_ADD: begin
                s_re = cau_pkg::clamp33({i_beat.a_real[31], i_beat.a_real}
                                       + {i_beat.b_real[31], i_beat.b_real});
                s_im = cau_pkg::clamp33({i_beat.a_imag[31], i_beat.a_imag}
                                       + {i_beat.b_imag[31], i_beat.b_imag});
            end
            cau_pkg::K_SUB: begin
                s_re = cau_pkg::clamp33({i_beat.a_real[31], i_beat.a_real}
                                       - {i_beat.b_real[31], i_beat.b_real});
                s_im = cau_pkg::clamp33({i_beat.a_imag[31], i_beat.a_imag}
                                       - {i_beat.b_imag[31], i_beat.b_imag});
            end
            cau_pkg::K_CONJ: begin
                s_re = cau_pkg::clamp33({i_beat.a_real[31], i_beat.a_real});
                s_im = cau_pkg::clamp33(-{i_beat.a_imag[31], i_beat.a_imag});
            end
            cau_pkg::K_NEG: begin
                s_re = cau_pkg::clamp33(-{i_beat.a_real[31], i_beat.a_real});
                s_im = cau_pkg::clamp33(-{i_beat.a_imag[31], i_beat.a_imag});
            end
            cau_pkg::K_DIV: begin
                n_w[0].zd = (i_beat.b_real == '0) && (i_beat.b_imag == '0);
            end
            cau_pkg::K_RECIP: begin
                n_w[0].zd = (i_beat.a_real == '0) && (i_beat.a_imag == '0);
            end
            cau_pkg::K_ANGLE: begin
                n_w[0].zd = ((i_beat.a_real == '0) && (i_beat.a_imag == '0))
                         || ((i_beat.b_real == '0) && (i_beat.b_imag == '0));
            end
            default: begin
            end
        endcase
        n_w[0].re  = s_re.val;
        n_w[0].im  = s_im.val;
        n_w[0].sat = s_re.sat | s_im.sat;

        // Stage 1: sums of products in sign and magnitude.
        n_w[1]     = r_w[0];
        n_w[1].d   = cau_pkg::to_sm(66'(r_w[0].p_rr) + 66'(r_w[0].p_ii));
        n_w[1].c   = cau_pkg::to_sm(66'(r_w[0].p_ir) - 66'(r_w[0].p_ri));
        n_w[1].mr  = cau_pkg::to_sm(66'(r_w[0].p_rr) - 66'(r_w[0].p_ii));
        n_w[1].mi  = cau_pkg::to_sm(66'(r_w[0].p_ri) + 66'(r_w[0].p_ir));
        n_w[1].den = r_w[0].sq_r + r_w[0].sq_i;

        // Stage 2: product rounding, division and root setup, angle vector.
        n_w[2] = r_w[1];
        rnd_r  = ({1'b0, r_w[1].mr.mag} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        rnd_i  = ({1'b0, r_w[1].mi.mag} + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        s_re   = cau_pkg::fin_sm(r_w[1].mr.neg, rnd_r);
        s_im   = cau_pkg::fin_sm(r_w[1].mi.neg, rnd_i);
        if (r_w[1].kind == cau_pkg::K_MUL) begin
            n_w[2].re  = s_re.val;
            n_w[2].im  = s_im.val;
            n_w[2].sat = s_re.sat | s_im.sat;
        end
        m_lane[0] = r_w[1].d.mag;
        m_lane[1] = r_w[1].c.mag;
        n_w[2].dv[0].neg = r_w[1].d.neg;
        n_w[2].dv[1].neg = r_w[1].c.neg;
        for (int l = 0; l < 2; l++) begin
            n_w[2].dv[l].rem = m_lane[l] >> RSH;
            n_w[2].dv[l].low = 34'(m_lane[l] << FRAC_BITS);
            n_w[2].dv[l].q   = '0;
            n_w[2].dv[l].ovf = (m_lane[l] >> RSH) >= r_w[1].den;
        end
        n_w[2].rad  = r_w[1].den;
        n_w[2].srem = '0;
        n_w[2].root = '0;
        n_w[2].ndm  = r_w[1].d.mag;
        n_w[2].ncm  = r_w[1].c.mag;
        n_w[2].nmx  = (r_w[1].d.mag > r_w[1].c.mag) ? r_w[1].d.mag : r_w[1].c.mag;

        // Stages 3 to 8: move the leading one of the larger part to bit 63.
        for (int k = 0; k < cau_pkg::NORM_STEPS; k++) begin
            sh = 32 >> k;
            n_w[3 + k] = r_w[2 + k];
            if ((r_w[2 + k].nmx >> (64 - sh)) == 64'd0) begin
                n_w[3 + k].nmx = r_w[2 + k].nmx << sh;
                n_w[3 + k].ndm = r_w[2 + k].ndm << sh;
                n_w[3 + k].ncm = r_w[2 + k].ncm << sh;
            end
        end

        // Stage 9: starting vector of the rotation, turned into the right half plane.
        n_w[9] = r_w[8];
        dmn    = {4'd0, r_w[8].ndm[63:34]};
        cmn    = {4'd0, r_w[8].ncm[63:34]};
        x0     = r_w[8].d.neg ? -dmn : dmn;
        if (x0 < 0) begin
            n_w[9].x = cmn;
            n_w[9].y = dmn;
            n_w[9].z = $signed(cau_pkg::HALF_PI_Q30);
        end else begin
            n_w[9].x = x0;
            n_w[9].y = cmn;
            n_w[9].z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                r_v[k] <= r_v[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_valid = r_v[NS - 1];
    assign o_work  = r_w[NS - 1];

endmodule

`default_nettype wire

// ----- hw/rtl/cau_cell.sv -----
// One cell of the iteration chain: a division step on both lanes, a square root step
// if IDX < SQRT_STEPS, a vectoring rotation if IDX < ANGLE_ITERATIONS. Uses cau_pkg.
`default_nettype none

module cau_cell #(
    parameter int IDX              = 0,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_en,
    input  wire             i_valid,
    input  cau_pkg::t_work  i_work,
    output logic            o_valid,
    output cau_pkg::t_work  o_work
);

    logic           r_v;
    cau_pkg::t_work r_w;
    cau_pkg::t_work n_w;

    logic [64:0]        rem2;
    logic [36:0]        t;
    logic [36:0]        trial;
    logic signed [33:0] dx, dy, at;

    always_comb begin
        n_w = i_work;

        // Restoring division: one quotient bit per lane.
        for (int l = 0; l < 2; l++) begin
            rem2 = {i_work.dv[l].rem, i_work.dv[l].low[33]};
            n_w.dv[l].low = {i_work.dv[l].low[32:0], 1'b0};
            if (rem2 >= {1'b0, i_work.den}) begin
                n_w.dv[l].rem = 64'(rem2 - {1'b0, i_work.den});
                n_w.dv[l].q   = {i_work.dv[l].q[32:0], 1'b1};
            end else begin
                n_w.dv[l].rem = rem2[63:0];
                n_w.dv[l].q   = {i_work.dv[l].q[32:0], 1'b0};
            end
        end

        // Restoring square root: one root bit while IDX < SQRT_STEPS.
        t     = {i_work.srem, i_work.rad[63:62]};
        trial = {3'd0, i_work.root, 2'b01};
        if (IDX < cau_pkg::SQRT_STEPS) begin
            n_w.rad = {i_work.rad[61:0], 2'b00};
            if (t >= trial) begin
                n_w.srem = 35'(t - trial);
                n_w.root = {i_work.root[30:0], 1'b1};
            end else begin
                n_w.srem = t[34:0];
                n_w.root = {i_work.root[30:0], 1'b0};
            end
        end

        // Vectoring rotation toward the positive real axis.
        dx = i_work.y >>> IDX;
        dy = i_work.x >>> IDX;
        at = $signed(cau_pkg::atan_q30(5'(IDX)));
        if (IDX < ANGLE_ITERATIONS) begin
            if (!i_work.y[33]) begin
                n_w.x = i_work.x + dx;
                n_w.y = i_work.y - dy;
                n_w.z = i_work.z + at;
            end else begin
                n_w.x = i_work.x - dx;
                n_w.y = i_work.y + dy;
                n_w.z = i_work.z - at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_valid = r_v;
    assign o_work  = r_w;

endmodule

`default_nettype wire

// ----- hw/rtl/cau_back.sv -----
// Back end: quotient and root rounding, angle scaling and the result register.
// Uses cau_pkg.
`default_nettype none

module cau_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_deg,
    input  wire                 i_valid,
    input  cau_pkg::t_work      i_work,
    output logic                o_valid,
    output cau_pkg::t_out_beat  o_beat
);

    logic               r_v1, r_v2;
    cau_pkg::t_work     r_w1, n_w1;
    cau_pkg::t_out_beat r_out, n_out;

    cau_pkg::t_sat32    lane [2];
    logic [34:0]        qr;
    logic [32:0]        rt;
    cau_pkg::t_sat32    s_a;
    logic [63:0]        ang;
    cau_pkg::t_sat32    s_ang;

    always_comb begin
        n_w1 = i_work;
        for (int l = 0; l < 2; l++) begin
            qr = {1'b0, i_work.dv[l].q}
               + 35'({i_work.dv[l].rem, 1'b0} >= {1'b0, i_work.den});
            lane[l] = cau_pkg::fin_sm(i_work.dv[l].neg, 65'(qr));
            if (i_work.dv[l].ovf) begin
                lane[l].sat = 1'b1;
                lane[l].val = i_work.dv[l].neg ? cau_pkg::NEG_MAX : cau_pkg::POS_MAX;
            end
        end
        rt  = {1'b0, i_work.root} + 33'({3'd0, i_work.root} < i_work.srem);
        s_a = cau_pkg::fin_sm(1'b0, 65'(rt));
        if (!i_work.zd) begin
            if (i_work.kind == cau_pkg::K_DIV || i_work.kind == cau_pkg::K_RECIP) begin
                n_w1.re  = lane[0].val;
                n_w1.im  = lane[1].val;
                n_w1.sat = lane[0].sat | lane[1].sat;
            end else if (i_work.kind == cau_pkg::K_MAG) begin
                n_w1.re  = s_a.val;
                n_w1.sat = s_a.sat;
            end
        end
        n_w1.zc   = i_work.z[33] ? 32'd0 : i_work.z[31:0];
        n_w1.angp = (i_work.z[33] ? 32'd0 : i_work.z[31:0]) * cau_pkg::DEG_PER_RAD_Q24;
    end

    always_comb begin
        if (i_deg) begin
            ang = (64'(r_w1.angp) + (64'd1 << (53 - FRAC_BITS))) >> (54 - FRAC_BITS);
        end else begin
            ang = (64'(r_w1.zc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        end
        s_ang              = cau_pkg::fin_sm(1'b0, 65'(ang));
        n_out.res_real     = r_w1.re;
        n_out.res_imag     = r_w1.im;
        n_out.zero_divisor = r_w1.zd;
        n_out.saturated    = r_w1.sat;
        if (r_w1.kind == cau_pkg::K_ANGLE && !r_w1.zd) begin
            n_out.res_real  = s_ang.val;
            n_out.saturated = s_ang.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w1  <= n_w1;
            r_out <= n_out;
        end
    end

    assign o_valid = r_v2;
    assign o_beat  = r_out;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the complex arithmetic unit: directed and random operand beats.
// Depends on cau_pkg and complex_arithmetic_unit; predicts every result in its own code.
`default_nettype none

module tb_top;

    // Expected results wait in a queue and are compared with the unit's results in order.
    class result_book;
        cau_pkg::t_out_beat pending_results[$];
        bit        in_degrees;
        int        mismatches;
        longint    atan_tab[16];

        function new();
            in_degrees = 1'b0;
            mismatches = 0;
            atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                         16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                         131072, 65536, 32768};
        endfunction

        function bit [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // Sign and magnitude into a clamped 32-bit word.
        function bit [31:0] clamp_sm(bit neg, bit [63:0] m, inout bit sat);
            if (!neg) begin
                if (m > 64'h7FFF_FFFF) begin
                    sat = 1'b1;
                    return 32'h7FFF_FFFF;
                end
                return m[31:0];
            end
            if (m > 64'h8000_0000) begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(64'd0 - m);
        endfunction

        function bit [31:0] clamp_int(longint v, inout bit sat);
            return clamp_sm(v < 0, mag(v), sat);
        endfunction

        function void mult_sm(longint x, longint y, output bit n, output bit [63:0] m);
            n = (x < 0) != (y < 0);
            m = mag(x) * mag(y);
            if (m == 0) n = 1'b0;
        endfunction

        function void add_sm(bit n1, bit [63:0] m1, bit n2, bit [63:0] m2,
                             output bit n, output bit [63:0] m);
            if (n1 == n2) begin
                n = n1;
                m = m1 + m2;
            end else if (m1 >= m2) begin
                n = n1;
                m = m1 - m2;
            end else begin
                n = n2;
                m = m2 - m1;
            end
            if (m == 0) n = 1'b0;
        endfunction

        // x*y plus or minus u*v, rounded back to 16 fraction bits.
        function bit [31:0] mul_acc(longint x, longint y, bit minus, longint u, longint v,
                                    inout bit sat);
            bit n1, n2, n;
            bit [63:0] m1, m2, m;
            mult_sm(x, y, n1, m1);
            mult_sm(u, v, n2, m2);
            if (minus && m2 != 0) n2 = !n2;
            add_sm(n1, m1, n2, m2, n, m);
            m = (m + (64'd1 << 15)) >> 16;
            return clamp_sm(n, m, sat);
        endfunction

        function bit [63:0] frac_quot(bit [63:0] num, bit [63:0] den);
            bit [63:0] rem, q, b;
            rem = 0;
            q = 0;
            for (int p = 79; p >= 0; p--) begin
                b = (p >= 16) ? ((num >> (p - 16)) & 64'd1) : 64'd0;
                rem = (rem << 1) | b;
                if ((q >> 40) != 0) q = 64'd1 << 40;
                q = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q = q | 64'd1;
                end
            end
            if (rem * 2 >= den) q = q + 1;
            return q;
        endfunction

        function void cplx_div(longint xr, longint xi, longint yr, longint yi,
                               output bit [31:0] re, output bit [31:0] im, inout bit sat);
            bit n1, n2, n;
            bit [63:0] m1, m2, m, den;
            den = mag(yr) * mag(yr) + mag(yi) * mag(yi);
            mult_sm(xr, yr, n1, m1);
            mult_sm(xi, yi, n2, m2);
            add_sm(n1, m1, n2, m2, n, m);
            re = clamp_sm(n, frac_quot(m, den), sat);
            mult_sm(xi, yr, n1, m1);
            mult_sm(xr, yi, n2, m2);
            if (m2 != 0) n2 = !n2;
            add_sm(n1, m1, n2, m2, n, m);
            im = clamp_sm(n, frac_quot(m, den), sat);
        endfunction

        function bit [63:0] round_sqrt(bit [63:0] s);
            bit [63:0] r, b, t;
            r = 0;
            b = 64'd1 << 62;
            t = s;
            while (b > t) b = b >> 2;
            while (b != 0) begin
                if (t >= r + b) begin
                    t = t - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            if (s - r * r > r) r = r + 1;
            return r;
        endfunction

        // atan2(|cross|, dot) by CORDIC vectoring, in radians or degrees.
        function bit [31:0] angle_of(longint ar, longint ai, longint br, longint bi,
                                     inout bit sat);
            bit dn, n1, n2, cn;
            bit [63:0] dm, cm, m1, m2, mx, zu;
            longint x, y, z, t, dx, dy;
            mult_sm(ar, br, n1, m1);
            mult_sm(ai, bi, n2, m2);
            add_sm(n1, m1, n2, m2, dn, dm);
            mult_sm(ar, bi, n1, m1);
            mult_sm(ai, br, n2, m2);
            if (m2 != 0) n2 = !n2;
            add_sm(n1, m1, n2, m2, cn, cm);
            mx = dm > cm ? dm : cm;
            while (mx >= (64'd1 << 30)) begin
                dm = dm >> 1;
                cm = cm >> 1;
                mx = mx >> 1;
            end
            while (mx < (64'd1 << 29)) begin
                dm = dm << 1;
                cm = cm << 1;
                mx = mx << 1;
            end
            x = dn ? -longint'(dm) : longint'(dm);
            y = longint'(cm);
            z = 0;
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                z = 1686629713;
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_tab[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_tab[i];
                end
            end
            if (z < 0) z = 0;
            zu = 64'(z);
            if (in_degrees) begin
                zu = zu * 64'd961263669;
                zu = (zu + (64'd1 << 37)) >> 38;
            end else begin
                zu = (zu + (64'd1 << 13)) >> 14;
            end
            return clamp_sm(1'b0, zu, sat);
        endfunction

        function cau_pkg::t_out_beat predict_result(cau_pkg::t_in_beat b);
            cau_pkg::t_out_beat r;
            longint ar, ai, br, bi;
            bit sat;
            bit [31:0] re, im;
            ar = longint'(b.a_real);
            ai = longint'(b.a_imag);
            br = longint'(b.b_real);
            bi = longint'(b.b_imag);
            sat = 1'b0;
            re = 0;
            im = 0;
            r = '0;
            case (b.kind)
                cau_pkg::K_ADD: begin
                    re = clamp_int(ar + br, sat);
                    im = clamp_int(ai + bi, sat);
                end
                cau_pkg::K_SUB: begin
                    re = clamp_int(ar - br, sat);
                    im = clamp_int(ai - bi, sat);
                end
                cau_pkg::K_MUL: begin
                    re = mul_acc(ar, br, 1'b1, ai, bi, sat);
                    im = mul_acc(ar, bi, 1'b0, ai, br, sat);
                end
                cau_pkg::K_DIV: begin
                    if (br == 0 && bi == 0) r.zero_divisor = 1'b1;
                    else cplx_div(ar, ai, br, bi, re, im, sat);
                end
                cau_pkg::K_CONJ: begin
                    re = clamp_int(ar, sat);
                    im = clamp_int(-ai, sat);
                end
                cau_pkg::K_RECIP: begin
                    if (ar == 0 && ai == 0) r.zero_divisor = 1'b1;
                    else cplx_div(longint'(65536), 0, ar, ai, re, im, sat);
                end
                cau_pkg::K_NEG: begin
                    re = clamp_int(-ar, sat);
                    im = clamp_int(-ai, sat);
                end
                cau_pkg::K_MAG: re = clamp_sm(1'b0,
                                              round_sqrt(mag(ar) * mag(ar) + mag(ai) * mag(ai)),
                                              sat);
                cau_pkg::K_ANGLE: begin
                    if ((ar == 0 && ai == 0) || (br == 0 && bi == 0)) r.zero_divisor = 1'b1;
                    else re = angle_of(ar, ai, br, bi, sat);
                end
                default: ;
            endcase
            r.res_real = re;
            r.res_imag = im;
            r.saturated = sat;
            return r;
        endfunction

        function void note_input(cau_pkg::t_in_beat b);
            pending_results.push_back(predict_result(b));
        endfunction

        function void check_result(cau_pkg::t_out_beat got);
            cau_pkg::t_out_beat exp_beat;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            exp_beat = pending_results.pop_front();
            if (got.res_real !== exp_beat.res_real || got.res_imag !== exp_beat.res_imag ||
                got.zero_divisor !== exp_beat.zero_divisor ||
                got.saturated !== exp_beat.saturated) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp re=%h im=%h zd=%b sat=%b got re=%h im=%h zd=%b sat=%b",
                             exp_beat.res_real, exp_beat.res_imag, exp_beat.zero_divisor,
                             exp_beat.saturated, got.res_real, got.res_imag,
                             got.zero_divisor, got.saturated);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    cau_pkg::t_in_beat  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cau_pkg::t_out_beat o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // When set, neither side idles, so the pipeline runs back to back.
    bit          no_gaps = 1'b0;
    result_book  book = new();

    complex_arithmetic_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver stalls at random, with a chance of 7 in 100, unless gaps are switched off.
    always @(posedge i_clk) begin
        i_out_ready <= no_gaps || ($urandom_range(99) >= 7);
    end

    // Both channels are watched at the clock edge, with values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) book.note_input(i_in_data);
        if (i_rst_n && o_out_valid && i_out_ready) book.check_result(o_out_data);
    end

    // Offers one operand beat and returns after an edge at which o_in_ready reads high.
    task automatic send_beat(cau_pkg::t_in_beat b);
        while (!no_gaps && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Lowers valid, then waits until every expected result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Register writes happen only with the pipeline empty; the extra wait covers its depth.
    task automatic write_units(bit degrees);
        drain();
        repeat (60) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'd0;
        pwdata <= {31'd0, degrees};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        book.in_degrees = degrees;
    endtask

    function automatic cau_pkg::t_in_beat mk(logic [3:0] k, logic [31:0] ar, logic [31:0] ai,
                                             logic [31:0] br, logic [31:0] bi);
        cau_pkg::t_in_beat b;
        b.kind = k;
        b.a_real = ar;
        b.a_imag = ai;
        b.b_real = br;
        b.b_imag = bi;
        return b;
    endfunction

    // Operand parts lean on extremes and small values, where the corner cases live.
    function automatic logic [31:0] rand_part();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 32'd0;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
            4, 5: return $urandom_range(1) ? 32'($urandom_range(1 << 20))
                                           : -32'($urandom_range(1 << 20));
            default: return $urandom;
        endcase
    endfunction

    function automatic cau_pkg::t_in_beat rand_beat();
        cau_pkg::t_in_beat b;
        b.kind = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
        b.a_real = rand_part();
        b.a_imag = rand_part();
        b.b_real = rand_part();
        b.b_imag = rand_part();
        if ($urandom_range(15) == 0) begin
            b.a_real = 0;
            b.a_imag = 0;
        end
        if ($urandom_range(15) == 0) begin
            b.b_real = 0;
            b.b_imag = 0;
        end
        return b;
    endfunction

    task automatic run_random(int count);
        for (int n = 0; n < count; n++) send_beat(rand_beat());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats: saturation on all paths but the angle, zero divisors, angle branches.
        send_beat(mk(cau_pkg::K_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h8000_0000));
        send_beat(mk(cau_pkg::K_ADD, 32'h0001_8000, 32'hFFFF_0000, 32'h0000_8000,
                     32'h0001_0000));
        send_beat(mk(cau_pkg::K_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000));
        send_beat(mk(cau_pkg::K_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000));
        send_beat(mk(cau_pkg::K_MUL, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000,
                     32'h0003_8000));
        send_beat(mk(cau_pkg::K_DIV, 32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_DIV, 32'h0005_0000, 32'hFFFE_0000, 32'h0001_0000,
                     32'h0002_0000));
        send_beat(mk(cau_pkg::K_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0));
        send_beat(mk(cau_pkg::K_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h1234_5678,
                     32'h9ABC_DEF0));
        send_beat(mk(cau_pkg::K_RECIP, 32'h0, 32'h0, 32'h1, 32'h1));
        send_beat(mk(cau_pkg::K_RECIP, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_RECIP, 32'h0000_0001, 32'h0, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_NEG, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_MAG, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_MAG, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(mk(cau_pkg::K_MAG, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0, 32'h0, 32'h0001_0000, 32'h0));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0000_0001));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                     32'h0002_0000));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF));
        send_beat(mk(4'd9, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        send_beat(mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // Degrees, with the angle extremes repeated in that unit.
        write_units(1'b1);
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0000_0001));
        send_beat(mk(cau_pkg::K_ANGLE, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000));
        run_random(500);
        // The sender holds off until the pipeline is fully drained, then resumes.
        drain();
        run_random(200);

        // Back to radians, with a long stretch that has no gaps on either side.
        write_units(1'b0);
        no_gaps = 1'b1;
        run_random(400);
        no_gaps = 1'b0;
        run_random(300);

        write_units(1'b1);
        run_random(350);

        drain();
        repeat (60) @(posedge i_clk);
        if (book.mismatches == 0 && book.pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_cell.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arithmetic_unit.sv
tb/sv/tb_top.sv
